// File: hw/rtl/pcm_pkg.sv
// shared types, constants and fixed-point helpers of the three-mode pid controller
package pcm_pkg;

	localparam int WIDE_W = 50;
	localparam int PROD_W = 65;
	localparam int IDX_W  = 3;
	localparam int DEC_W  = 17;

	// deadbands, q16.16 magnitudes
	localparam logic [31:0] ERROR_DEADBAND  = 32'd0;
	localparam logic [31:0] OUTPUT_DEADBAND = 32'd0;

	localparam logic [1:0] MODE_INC   = 2'd0;
	localparam logic [1:0] MODE_POS   = 2'd1;
	localparam logic [1:0] MODE_DECAY = 2'd2;
	localparam logic [1:0] MODE_HOLD  = 2'd3;

	localparam logic [IDX_W-1:0] REG_MODE   = 3'd0;
	localparam logic [IDX_W-1:0] REG_GAIN_P = 3'd1;
	localparam logic [IDX_W-1:0] REG_GAIN_I = 3'd2;
	localparam logic [IDX_W-1:0] REG_GAIN_D = 3'd3;
	localparam logic [IDX_W-1:0] REG_ILIM   = 3'd4;
	localparam logic [IDX_W-1:0] REG_PLIM   = 3'd5;
	localparam logic [IDX_W-1:0] REG_OLIM   = 3'd6;
	localparam logic [IDX_W-1:0] REG_DECAY  = 3'd7;

	typedef struct packed {
		logic [1:0]          mode;
		logic signed [31:0]  gain_p;
		logic signed [31:0]  gain_i;
		logic signed [31:0]  gain_d;
		logic signed [31:0]  integral_limit;
		logic signed [31:0]  p_term_limit;
		logic signed [31:0]  output_limit;
		logic [DEC_W-1:0]    decay_factor;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ERR,
		ST_DIFF,
		ST_MDEC,
		ST_MULP,
		ST_MULD,
		ST_MULI,
		ST_MULL,
		ST_MWB,
		ST_FIN1,
		ST_FIN2,
		ST_DONE,
		ST_CLEAR
	} state_t;

	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_DEC,
		MUL_P,
		MUL_D,
		MUL_I,
		MUL_L
	} mul_op_t;

	typedef enum logic [2:0] {
		DP_NONE,
		DP_ERR,
		DP_DIFF,
		DP_FIN1,
		DP_FIN2,
		DP_COMMIT,
		DP_CLEAR
	} dp_op_t;

	typedef struct packed {
		logic    load;
		dp_op_t  op;
		mul_op_t mul;
	} dp_cmd_t;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] val;
	} res_t;

	function automatic logic signed [WIDE_W-1:0] sx(input logic signed [31:0] v);
		return WIDE_W'(v);
	endfunction

	function automatic res_t sat32(input logic signed [WIDE_W-1:0] v);
		res_t r;
		if (v > sx(32'sh7fffffff)) begin
			r.hit = 1'b1;
			r.val = 32'sh7fffffff;
		end else if (v < sx(32'sh80000000)) begin
			r.hit = 1'b1;
			r.val = 32'sh80000000;
		end else begin
			r.hit = 1'b0;
			r.val = v[31:0];
		end
		return r;
	endfunction

	// symmetric clamp, a negative limit leaves the value alone
	function automatic res_t trim(input logic signed [31:0] v, input logic signed [31:0] lim);
		res_t r;
		logic signed [32:0] neg_lim;
		neg_lim = -33'(lim);
		r.hit = 1'b0;
		r.val = v;
		if (!lim[31]) begin
			if (33'(v) < neg_lim) begin
				r.hit = 1'b1;
				r.val = neg_lim[31:0];
			end else if (v > lim) begin
				r.hit = 1'b1;
				r.val = lim;
			end
		end
		return r;
	endfunction

	function automatic logic [32:0] mag33(input logic signed [31:0] v);
		logic signed [32:0] w;
		w = 33'(v);
		return v[31] ? 33'(-w) : 33'(w);
	endfunction

endpackage

// File: hw/rtl/pcm_regs.sv
// configuration registers of the pid controller
module pcm_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pcm_pkg::IDX_W-1:0]       cfg_index,
	input  logic [31:0]                     cfg_data,
	output pcm_pkg::cfg_t                   cfg
);
	import pcm_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode           <= MODE_POS;
			cfg_q.gain_p         <= '0;
			cfg_q.gain_i         <= '0;
			cfg_q.gain_d         <= '0;
			cfg_q.integral_limit <= -32'sd65536;
			cfg_q.p_term_limit   <= -32'sd65536;
			cfg_q.output_limit   <= -32'sd65536;
			cfg_q.decay_factor   <= 17'd65536;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:   cfg_q.mode           <= cfg_data[1:0];
				REG_GAIN_P: cfg_q.gain_p         <= cfg_data;
				REG_GAIN_I: cfg_q.gain_i         <= cfg_data;
				REG_GAIN_D: cfg_q.gain_d         <= cfg_data;
				REG_ILIM:   cfg_q.integral_limit <= cfg_data;
				REG_PLIM:   cfg_q.p_term_limit   <= cfg_data;
				REG_OLIM:   cfg_q.output_limit   <= cfg_data;
				REG_DECAY:  cfg_q.decay_factor   <= cfg_data[DEC_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: hw/rtl/pcm_ctrl.sv
// sequencing state machine of the pid controller
module pcm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        mode,
	input  logic              s_tvalid,
	input  logic              s_tuser,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	output pcm_pkg::dp_cmd_t  cmd
);
	import pcm_pkg::*;

	state_t state_q, state_nxt;
	logic   out_valid_q;
	logic   out_free;
	logic   fire;

	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_nxt = s_tuser ? ST_CLEAR : ST_ERR;
			end
			ST_ERR: state_nxt = ST_DIFF;
			ST_DIFF: begin
				case (mode)
					MODE_DECAY: state_nxt = ST_MDEC;
					MODE_HOLD:  state_nxt = ST_DONE;
					default:    state_nxt = ST_MULP;
				endcase
			end
			ST_MDEC: state_nxt = ST_MULP;
			ST_MULP: state_nxt = ST_MULD;
			ST_MULD: state_nxt = ST_MULI;
			ST_MULI: state_nxt = (mode == MODE_INC) ? ST_MULL : ST_MWB;
			ST_MULL: state_nxt = ST_MWB;
			ST_MWB:  state_nxt = ST_FIN1;
			ST_FIN1: state_nxt = ST_FIN2;
			ST_FIN2: state_nxt = ST_DONE;
			ST_DONE: begin
				if (out_free) state_nxt = ST_IDLE;
			end
			ST_CLEAR: begin
				if (out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		fire     = 1'b0;
		cmd.load = 1'b0;
		cmd.op   = DP_NONE;
		cmd.mul  = MUL_NONE;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			ST_ERR:  cmd.op  = DP_ERR;
			ST_DIFF: cmd.op  = DP_DIFF;
			ST_MDEC: cmd.mul = MUL_DEC;
			ST_MULP: cmd.mul = MUL_P;
			ST_MULD: cmd.mul = MUL_D;
			ST_MULI: cmd.mul = MUL_I;
			ST_MULL: cmd.mul = MUL_L;
			ST_FIN1: cmd.op  = DP_FIN1;
			ST_FIN2: cmd.op  = DP_FIN2;
			ST_DONE: begin
				fire   = out_free;
				cmd.op = out_free ? DP_COMMIT : DP_NONE;
			end
			ST_CLEAR: begin
				fire   = out_free;
				cmd.op = out_free ? DP_CLEAR : DP_NONE;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (fire) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

// File: hw/rtl/pcm_dp.sv
// datapath of the pid controller: error history, shared multiplier, sums and clamps
module pcm_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  pcm_pkg::cfg_t     cfg,
	input  pcm_pkg::dp_cmd_t  cmd,
	input  logic [63:0]       s_tdata,
	output logic [31:0]       m_tdata,
	output logic              m_tuser
);
	import pcm_pkg::*;

	logic signed [31:0] tgt_q, meas_q;
	logic signed [31:0] e_q, prev_q, prev2_q, sum_q, held_q;
	logic signed [31:0] dp_q, dd_q, p_q, i_q, d_q, lim_q;
	logic               sat_q;
	logic [31:0]        out_data_q;
	logic               out_sat_q;

	logic signed [PROD_W-1:0] prod_s1;
	mul_op_t                  tag_s1;

	logic signed [31:0]       mul_a;
	logic signed [32:0]       mul_b;
	logic signed [PROD_W-1:0] prod;
	logic signed [48:0]       scaled;

	res_t        e_raw, diff1, diff2, sum_add, sum_pos;
	res_t        wb_gain, wb_dec, dec_trim, i_trim, p_trim, tot, tot_trim;
	logic signed [31:0] e_db;
	logic        inc;

	assign inc = (cfg.mode == MODE_INC);

	assign e_raw = sat32(sx(tgt_q) - sx(meas_q));
	assign e_db  = (mag33(e_raw.val) < {1'b0, ERROR_DEADBAND}) ? 32'sd0 : e_raw.val;

	assign diff1   = sat32(sx(e_q) - sx(prev_q));
	assign diff2   = sat32(sx(e_q) - (sx(prev_q) <<< 1) + sx(prev2_q));
	assign sum_add = sat32(sx(sum_q) + sx(e_q));
	assign sum_pos = trim(sum_add.val, cfg.integral_limit);

	// q16.16 product, floor of product / 2^16
	assign scaled   = prod_s1[PROD_W-1:16];
	assign wb_gain  = sat32(WIDE_W'(scaled));
	assign wb_dec   = sat32(WIDE_W'(scaled) + sx(e_q));
	assign dec_trim = trim(wb_dec.val, cfg.integral_limit);

	assign i_trim   = trim(i_q, lim_q);
	assign p_trim   = trim(p_q, cfg.p_term_limit);
	assign tot      = inc ? sat32(sx(held_q) + sx(p_q) + sx(i_q) + sx(d_q))
	                      : sat32(sx(p_q) + sx(i_q) + sx(d_q));
	assign tot_trim = trim(tot.val, cfg.output_limit);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.mul)
			MUL_DEC: begin
				mul_a = sum_q;
				mul_b = $signed({16'd0, cfg.decay_factor});
			end
			MUL_P: begin
				mul_a = cfg.gain_p;
				mul_b = inc ? 33'(dp_q) : 33'(e_q);
			end
			MUL_D: begin
				mul_a = cfg.gain_d;
				mul_b = 33'(dd_q);
			end
			MUL_I: begin
				mul_a = cfg.gain_i;
				mul_b = inc ? 33'(e_q) : 33'(sum_q);
			end
			MUL_L: begin
				mul_a = cfg.integral_limit;
				mul_b = 33'(cfg.gain_i);
			end
			default: begin
			end
		endcase
	end

	assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

	always_ff @(posedge clk) begin
		prod_s1 <= prod;
		if (cmd.load) begin
			tgt_q  <= s_tdata[31:0];
			meas_q <= s_tdata[63:32];
		end
	end

	// writebacks and datapath ops never fall in the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1     <= MUL_NONE;
			e_q        <= '0;
			prev_q     <= '0;
			prev2_q    <= '0;
			sum_q      <= '0;
			held_q     <= '0;
			dp_q       <= '0;
			dd_q       <= '0;
			p_q        <= '0;
			i_q        <= '0;
			d_q        <= '0;
			lim_q      <= '0;
			sat_q      <= 1'b0;
			out_data_q <= '0;
			out_sat_q  <= 1'b0;
		end else begin
			tag_s1 <= cmd.mul;
			case (tag_s1)
				MUL_DEC: begin
					sum_q <= dec_trim.val;
					sat_q <= sat_q | wb_dec.hit | dec_trim.hit;
				end
				MUL_P: begin
					p_q   <= wb_gain.val;
					sat_q <= sat_q | wb_gain.hit;
				end
				MUL_D: begin
					d_q   <= wb_gain.val;
					sat_q <= sat_q | wb_gain.hit;
				end
				MUL_I: begin
					i_q   <= wb_gain.val;
					sat_q <= sat_q | wb_gain.hit;
				end
				MUL_L: begin
					lim_q <= wb_gain.val;
					sat_q <= sat_q | wb_gain.hit;
				end
				default: begin
				end
			endcase
			case (cmd.op)
				DP_ERR: begin
					e_q   <= e_db;
					sat_q <= e_raw.hit;
				end
				DP_DIFF: begin
					case (cfg.mode)
						MODE_INC: begin
							dp_q  <= diff1.val;
							dd_q  <= diff2.val;
							sat_q <= sat_q | diff1.hit | diff2.hit;
						end
						MODE_POS: begin
							dd_q  <= diff1.val;
							sum_q <= sum_pos.val;
							sat_q <= sat_q | diff1.hit | sum_add.hit | sum_pos.hit;
						end
						MODE_DECAY: begin
							dd_q  <= diff1.val;
							sat_q <= sat_q | diff1.hit;
						end
						default: begin
						end
					endcase
				end
				DP_FIN1: begin
					if (inc) begin
						i_q   <= i_trim.val;
						sat_q <= sat_q | i_trim.hit;
					end else begin
						p_q   <= p_trim.val;
						sat_q <= sat_q | p_trim.hit;
					end
				end
				DP_FIN2: begin
					held_q <= tot_trim.val;
					sat_q  <= sat_q | tot.hit | tot_trim.hit;
				end
				DP_COMMIT: begin
					prev2_q    <= prev_q;
					prev_q     <= e_q;
					out_data_q <= (mag33(held_q) < {1'b0, OUTPUT_DEADBAND}) ? 32'd0 : held_q;
					out_sat_q  <= sat_q;
				end
				DP_CLEAR: begin
					prev_q     <= '0;
					prev2_q    <= '0;
					sum_q      <= '0;
					held_q     <= '0;
					out_data_q <= '0;
					out_sat_q  <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	assign m_tdata = out_data_q;
	assign m_tuser = out_sat_q;

endmodule

// File: hw/rtl/pid_controller_three_mode.sv
// top level of the three-mode q16.16 pid controller
// Takes one item at a time: a target and a measurement (or a clear command) in, one
// drive value and a saturation flag out. All products go one after another through a
// single shared 32 x 33 bit multiplier with a registered product. An update goes through
// the error and difference states, the products (decay in integral-decay mode, then p,
// d and i, and the i limit in incremental mode), a writeback state and the finish states;
// hold mode goes from the difference state straight to done, and a clear command goes
// straight to its clear state. Done and clear wait while the previous result has not been
// taken from the output register. The next item is taken while a result still waits on the
// output. Configuration may be written only while no item is in flight.
module pid_controller_three_mode (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [pcm_pkg::IDX_W-1:0] cfg_index,
	input  logic [31:0]               cfg_data,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [63:0]               s_tdata,   // target [31:0], measure [63:32]
	input  logic                      s_tuser,   // command
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [31:0]               m_tdata,   // control_out [31:0]
	output logic                      m_tuser    // saturated
);
	import pcm_pkg::*;

	cfg_t    cfg;
	dp_cmd_t cmd;

	pcm_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pcm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.mode     (cfg.mode),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	pcm_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.cmd     (cmd),
		.s_tdata (s_tdata),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench for the three-mode pid controller, directed and random items
module testbench;
	import pcm_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int STALL_CYCLES = 120;
	localparam logic CMD_UPDATE = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;
	localparam logic signed [31:0] Q_ONE = 32'sh10000;
	localparam logic signed [31:0] Q_TOP = 32'sh7fffffff;
	localparam logic signed [31:0] Q_BOTTOM = 32'sh80000000;
	localparam longint Q_MAX = 64'sd2147483647;
	localparam longint Q_MIN = -64'sd2147483648;

	typedef struct {
		logic signed [31:0] value;
		logic sat;
	} drive_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [63:0] s_tdata = '0;   // target [31:0], measure [63:32]
	logic s_tuser = 1'b0;        // command
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [31:0] m_tdata;        // control_out [31:0]
	logic m_tuser;               // saturated

	// predictor copy of the registers and loop state
	cfg_t tune;
	logic signed [31:0] err_last = 0;
	logic signed [31:0] err_last2 = 0;
	logic signed [31:0] err_integral = 0;
	logic signed [31:0] drive_held = 0;

	drive_t drive_queue[$];
	int fail_count = 0;
	int items_sent = 0;
	int results_seen = 0;
	int settings_used = 0;
	int unsigned cycle_count = 0;
	logic steady = 1'b0;
	int stall_asked = 0;
	int stall_done = 0;
	int stall_left = 0;

	pid_controller_three_mode dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic logic signed [31:0] clip32(input longint v, inout logic hit);
		if (v > Q_MAX) begin
			hit = 1'b1;
			return Q_TOP;
		end
		if (v < Q_MIN) begin
			hit = 1'b1;
			return Q_BOTTOM;
		end
		return v[31:0];
	endfunction

	// q16.16 product, floor rounding
	function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
			input logic signed [31:0] b, inout logic hit);
		longint prod;
		prod = longint'(a) * longint'(b);
		return clip32(prod >>> 16, hit);
	endfunction

	function automatic logic signed [31:0] bound(input logic signed [31:0] v,
			input logic signed [31:0] lim, inout logic hit);
		if (lim < 0)
			return v;
		if (longint'(v) < -longint'(lim)) begin
			hit = 1'b1;
			return -lim;
		end
		if (v > lim) begin
			hit = 1'b1;
			return lim;
		end
		return v;
	endfunction

	function automatic drive_t pid_predict(input logic cmd, input logic signed [31:0] tgt,
			input logic signed [31:0] meas);
		drive_t r;
		logic hit;
		logic signed [31:0] e, p, i, d, lim, delta;
		longint mag;
		hit = 1'b0;
		if (cmd == CMD_CLEAR) begin
			err_last = 0;
			err_last2 = 0;
			err_integral = 0;
			drive_held = 0;
			r.value = 0;
			r.sat = 1'b0;
			return r;
		end
		e = clip32(longint'(tgt) - longint'(meas), hit);
		mag = (e < 0) ? -longint'(e) : longint'(e);
		if (mag < longint'(ERROR_DEADBAND))
			e = 0;
		case (tune.mode)
			MODE_INC: begin
				delta = clip32(longint'(e) - longint'(err_last), hit);
				p = qmul(tune.gain_p, delta, hit);
				i = qmul(tune.gain_i, e, hit);
				delta = clip32(longint'(e) - 2 * longint'(err_last) + longint'(err_last2), hit);
				d = qmul(tune.gain_d, delta, hit);
				// i clamp is ki times the integral limit, skipped when that is negative
				lim = qmul(tune.integral_limit, tune.gain_i, hit);
				i = bound(i, lim, hit);
				drive_held = clip32(longint'(drive_held) + longint'(p) + longint'(i)
					+ longint'(d), hit);
				drive_held = bound(drive_held, tune.output_limit, hit);
			end
			MODE_POS, MODE_DECAY: begin
				if (tune.mode == MODE_POS) begin
					err_integral = clip32(longint'(err_integral) + longint'(e), hit);
				end else begin
					err_integral = clip32(((longint'(err_integral)
						* longint'(tune.decay_factor)) >>> 16) + longint'(e), hit);
				end
				err_integral = bound(err_integral, tune.integral_limit, hit);
				p = qmul(tune.gain_p, e, hit);
				i = qmul(tune.gain_i, err_integral, hit);
				delta = clip32(longint'(e) - longint'(err_last), hit);
				d = qmul(tune.gain_d, delta, hit);
				p = bound(p, tune.p_term_limit, hit);
				drive_held = clip32(longint'(p) + longint'(i) + longint'(d), hit);
				drive_held = bound(drive_held, tune.output_limit, hit);
			end
			default: begin
			end
		endcase
		err_last2 = err_last;
		err_last = e;
		r.value = drive_held;
		mag = (drive_held < 0) ? -longint'(drive_held) : longint'(drive_held);
		if (mag < longint'(OUTPUT_DEADBAND))
			r.value = 0;
		r.sat = hit;
		return r;
	endfunction

	function automatic cfg_t reset_config();
		cfg_t c;
		c = '0;
		c.mode = MODE_POS;
		c.integral_limit = -Q_ONE;
		c.p_term_limit = -Q_ONE;
		c.output_limit = -Q_ONE;
		c.decay_factor = 17'h10000;
		return c;
	endfunction

	function automatic logic signed [31:0] rand_q();
		case ($urandom_range(9))
			0, 1, 2, 3: return $urandom_range(0, 32'h3ffff) - 32'h20000;
			4, 5, 6: return $urandom_range(0, 32'h1ffffff) - 32'h1000000;
			7, 8: return $urandom;
			default: begin
				case ($urandom_range(3))
					0: return Q_TOP;
					1: return Q_BOTTOM;
					2: return 0;
					default: return -1;
				endcase
			end
		endcase
	endfunction

	function automatic logic signed [31:0] rand_gain();
		case ($urandom_range(19))
			0, 1: return 0;
			2, 3, 4: return $urandom;
			5: return Q_TOP;
			6: return Q_BOTTOM;
			default: return $urandom_range(0, 32'hfffff) - 32'h80000;
		endcase
	endfunction

	function automatic logic signed [31:0] rand_limit();
		case ($urandom_range(19))
			0, 1, 2, 3, 4: return -Q_ONE;
			5, 6, 7: return 0;
			8, 9: return Q_TOP;
			default: return $urandom_range(1, 32'h400000);
		endcase
	endfunction

	function automatic cfg_t rand_config(input logic [1:0] mode);
		cfg_t c;
		c.mode = mode;
		c.gain_p = rand_gain();
		c.gain_i = rand_gain();
		c.gain_d = rand_gain();
		c.integral_limit = rand_limit();
		c.p_term_limit = rand_limit();
		c.output_limit = rand_limit();
		case ($urandom_range(9))
			0: c.decay_factor = 17'h0;
			1, 2: c.decay_factor = 17'h10000;
			3: c.decay_factor = 17'($urandom_range(17'h10001, 17'h1ffff));
			default: c.decay_factor = 17'($urandom_range(0, 17'h10000));
		endcase
		return c;
	endfunction

	// all eight registers in a burst, block must be idle
	task automatic load_config(input cfg_t c);
		cfg_we <= 1'b1;
		cfg_index <= REG_MODE;
		cfg_data <= {30'b0, c.mode};
		@(posedge clk);
		cfg_index <= REG_GAIN_P;
		cfg_data <= c.gain_p;
		@(posedge clk);
		cfg_index <= REG_GAIN_I;
		cfg_data <= c.gain_i;
		@(posedge clk);
		cfg_index <= REG_GAIN_D;
		cfg_data <= c.gain_d;
		@(posedge clk);
		cfg_index <= REG_ILIM;
		cfg_data <= c.integral_limit;
		@(posedge clk);
		cfg_index <= REG_PLIM;
		cfg_data <= c.p_term_limit;
		@(posedge clk);
		cfg_index <= REG_OLIM;
		cfg_data <= c.output_limit;
		@(posedge clk);
		cfg_index <= REG_DECAY;
		cfg_data <= {15'b0, c.decay_factor};
		@(posedge clk);
		cfg_we <= 1'b0;
		tune = c;
		settings_used++;
	endtask

	task automatic send_item(input logic cmd, input logic signed [31:0] tgt,
			input logic signed [31:0] meas);
		if (!steady && $urandom_range(99) < 18) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {meas, tgt};
		s_tuser <= cmd;
		do
			@(posedge clk);
		while (!s_tready);
		drive_queue.push_back(pid_predict(cmd, tgt, meas));
		items_sent++;
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (drive_queue.size() != 0)
			@(posedge clk);
	endtask

	// receiver ready: random idles, or a long hold-off when one is asked for
	always @(posedge clk) begin
		if (stall_left != 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (stall_asked != stall_done) begin
			m_tready <= 1'b0;
			stall_left <= STALL_CYCLES;
			stall_done <= stall_done + 1;
		end else begin
			m_tready <= steady || ($urandom_range(99) >= 18);
		end
	end

	always @(posedge clk) begin : check_results
		drive_t want;
		if (m_tvalid && m_tready) begin
			results_seen++;
			if (drive_queue.size() == 0) begin
				$error("result with no item pending: control_out %0d saturated %0b",
					$signed(m_tdata), m_tuser);
				fail_count++;
			end else begin
				want = drive_queue.pop_front();
				if (m_tdata !== want.value) begin
					$error("control_out: expected %0d, got %0d", want.value, $signed(m_tdata));
					fail_count++;
				end
				if (m_tuser !== want.sat) begin
					$error("saturated: expected %0b, got %0b", want.sat, m_tuser);
					fail_count++;
				end
			end
		end
	end

	// reset values: zero gains, so only error saturation shows
	task automatic test_reset_values();
		send_item(CMD_UPDATE, Q_TOP, Q_BOTTOM);
		send_item(CMD_UPDATE, Q_BOTTOM, Q_TOP);
		send_item(CMD_UPDATE, 0, 0);
		send_item(CMD_CLEAR, $urandom, $urandom);
		drain_results();
	endtask

	task automatic test_incremental();
		cfg_t c;
		c = reset_config();
		c.mode = MODE_INC;
		c.gain_p = Q_ONE;
		c.gain_i = Q_ONE / 2;
		c.gain_d = Q_ONE / 4;
		load_config(c);
		send_item(CMD_UPDATE, 3 * Q_ONE, Q_ONE);
		send_item(CMD_UPDATE, 3 * Q_ONE, 2 * Q_ONE);
		send_item(CMD_UPDATE, Q_ONE, 5 * Q_ONE / 2);
		drain_results();
		// negative ki with a negative integral limit gives a positive i clamp
		c.gain_i = -Q_ONE / 2;
		c.output_limit = 2 * Q_ONE;
		load_config(c);
		send_item(CMD_UPDATE, 4 * Q_ONE, 0);
		send_item(CMD_UPDATE, -4 * Q_ONE, 0);
		drain_results();
	endtask

	task automatic test_positional_limits();
		cfg_t c;
		c = reset_config();
		c.gain_p = 3 * Q_ONE / 2;
		c.gain_i = 3 * Q_ONE / 4;
		c.gain_d = -Q_ONE / 2;
		c.integral_limit = 2 * Q_ONE;
		c.p_term_limit = Q_ONE;
		c.output_limit = 3 * Q_ONE;
		load_config(c);
		send_item(CMD_UPDATE, 5 * Q_ONE, 0);
		send_item(CMD_UPDATE, 5 * Q_ONE, 0);
		send_item(CMD_UPDATE, -8 * Q_ONE, Q_ONE);
		send_item(CMD_UPDATE, Q_ONE / 4, 0);
		drain_results();
	endtask

	task automatic test_decay();
		cfg_t c;
		c = reset_config();
		c.mode = MODE_DECAY;
		c.gain_p = Q_ONE / 2;
		c.gain_i = Q_ONE;
		c.decay_factor = 17'h1ffff;
		load_config(c);
		// factor near two doubles the sum until it saturates
		send_item(CMD_UPDATE, 100 * Q_ONE, 0);
		send_item(CMD_UPDATE, 20000 * Q_ONE, 0);
		send_item(CMD_UPDATE, 30000 * Q_ONE, 0);
		drain_results();
		c.decay_factor = 17'h0;
		load_config(c);
		send_item(CMD_UPDATE, Q_ONE, 0);
		send_item(CMD_UPDATE, -Q_ONE, Q_ONE);
		drain_results();
	endtask

	task automatic test_hold_and_clear();
		cfg_t c;
		c = tune;
		c.mode = MODE_HOLD;
		load_config(c);
		send_item(CMD_UPDATE, 7 * Q_ONE, 0);
		send_item(CMD_UPDATE, Q_BOTTOM, Q_TOP);
		send_item(CMD_CLEAR, Q_TOP, Q_BOTTOM);
		send_item(CMD_UPDATE, Q_ONE, 0);
		drain_results();
	endtask

	task automatic test_gain_extremes();
		cfg_t c;
		c = reset_config();
		c.mode = MODE_INC;
		c.gain_p = Q_BOTTOM;
		c.gain_i = Q_TOP;
		c.gain_d = Q_BOTTOM;
		c.integral_limit = Q_TOP;
		c.p_term_limit = Q_TOP;
		c.output_limit = Q_TOP;
		load_config(c);
		send_item(CMD_UPDATE, Q_TOP, Q_BOTTOM);
		send_item(CMD_UPDATE, -1, 0);
		drain_results();
		c.mode = MODE_POS;
		c.gain_p = Q_TOP;
		load_config(c);
		send_item(CMD_UPDATE, Q_BOTTOM, Q_ONE);
		drain_results();
	endtask

	// long receiver hold-off while items keep coming, no idles on either side
	task automatic test_backpressure();
		int k;
		load_config(rand_config(MODE_INC));
		steady = 1'b1;
		stall_asked <= stall_asked + 1;
		for (k = 0; k < 20; k++)
			send_item(CMD_UPDATE, rand_q(), rand_q());
		drain_results();
		steady = 1'b0;
	endtask

	// mostly a tracking loop: measurement follows the setpoint, some noise and clears
	task automatic run_loop_phase(input int count);
		logic signed [31:0] sp, pv;
		logic junk;
		int k, roll;
		junk = 1'b0;
		sp = rand_q();
		pv = rand_q();
		for (k = 0; k < count; k++) begin
			roll = $urandom_range(99);
			if (roll < 5) begin
				send_item(CMD_CLEAR, $urandom, $urandom);
			end else if (roll < 15) begin
				send_item(CMD_UPDATE, rand_q(), rand_q());
			end else begin
				if ($urandom_range(9) == 0)
					sp = rand_q();
				pv = clip32(longint'(pv) + (longint'(sp) - longint'(pv)) / 4
					+ longint'($urandom_range(0, 8191)) - 4096, junk);
				send_item(CMD_UPDATE, sp, pv);
			end
		end
		drain_results();
	endtask

	task automatic test_random_loops();
		int ph;
		logic [1:0] mode;
		for (ph = 0; ph < 13; ph++) begin
			mode = (ph < 4) ? 2'(ph) : 2'($urandom_range(3));
			load_config(rand_config(mode));
			if (ph == 6)
				steady = 1'b1;
			run_loop_phase(70);
			if (ph == 6)
				steady = 1'b0;
		end
	endtask

	initial begin
		tune = reset_config();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_incremental();
		test_positional_limits();
		test_decay();
		test_hold_and_clear();
		test_gain_extremes();
		test_random_loops();
		test_backpressure();
		repeat (20) @(posedge clk);
		$display("run covered %0d items and %0d results over %0d register settings,",
			items_sent, results_seen, settings_used);
		$display("all four modes, clear commands, clamps, saturation and output hold-off");
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/pcm_pkg.sv
hw/rtl/pcm_regs.sv
hw/rtl/pcm_ctrl.sv
hw/rtl/pcm_dp.sv
hw/rtl/pid_controller_three_mode.sv
tb/sv/testbench.sv
